// ===== rtl/glad_pkg.sv =====
// Shared types, constants and helpers for the greedy line-art drawer.
// No dependencies.
package glad_pkg;

    localparam int ImgWidth   = 256;
    localparam int ImgHeight  = 256;
    localparam int AddrW      = 16;
    localparam int CoordW     = 13;   // signed coordinates, room for -4096..4095
    localparam int Grid       = 29;
    localparam int NumCand    = 112;
    localparam int Split      = 58;
    localparam int SideRows   = 27;
    localparam int CandOff    = 5;
    localparam int SumW       = 16;   // at most 24 points of 8 bits
    localparam int CntW       = 7;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_DRAW = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic [0:0] CFG_INVERT   = 1'b0;
    localparam logic [0:0] CFG_DARKNESS = 1'b1;

    typedef logic signed [CoordW-1:0] coord_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [AddrW-1:0] pixel_addr;
        logic [7:0]       in_pixel;
    } req_t;

    typedef struct packed {
        logic       reply_kind;
        logic [7:0] from_x;
        logic [7:0] from_y;
        logic [7:0] to_x;
        logic [7:0] to_y;
        logic [7:0] out_pixel;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRID_RD,
        ST_GRID_CMP,
        ST_CAND_INIT,
        ST_DIV,
        ST_PT_RD,
        ST_PT_ACC,
        ST_CAND_END,
        ST_PAINT_INIT,
        ST_PAINT_DIV,
        ST_PAINT_RD,
        ST_PAINT_WR,
        ST_READ,
        ST_DONE
    } state_t;

    // Control from the sequencer to the line stepper.
    typedef struct packed {
        logic   start;      // load a new line
        logic   div_go;     // start division for current point
        logic   advance;    // step to next point
    } step_ctl_t;

    typedef struct packed {
        logic   div_busy;
        logic   last;       // current point is the final one
        logic   empty;      // line has no points
    } step_sts_t;

    function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [7:0] d);
        logic [8:0] s;
        s = {1'b0, v} + {1'b0, d};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    function automatic logic [7:0] sat_sub(input logic [7:0] v, input logic [7:0] d);
        return (v > d) ? v - d : 8'h00;
    endfunction

endpackage

// ===== rtl/glad_if.sv =====
// Valid/ready channel interface carrying one request or response.
// Depends on glad_pkg.
interface glad_req_if;
    glad_pkg::req_t data;
    logic           valid;
    logic           ready;
    modport source (output data, output valid, input ready);
    modport sink   (input data, input valid, output ready);
endinterface

interface glad_rsp_if;
    glad_pkg::rsp_t data;
    logic           valid;
    logic           ready;
    modport source (output data, output valid, input ready);
    modport sink   (input data, input valid, output ready);
endinterface

// ===== rtl/greedy_line_art_drawer.sv =====
// Top level of the greedy line-art drawer: configuration registers and channels.
// Depends on glad_pkg, glad_if and glad_core.
//
//   channel   dir   content
//   req       in    func, pixel_addr, in_pixel
//   rsp       out   reply_kind, from_x, from_y, to_x, to_y, out_pixel
//   cfg       in    cfg_we, cfg_index, cfg_wdata
//
// A load is written in the idle state; a read passes through the read state to the done state.
// A draw scans the grid, then for each of 112 candidates walks its line points
// (the 16-step divider in the stepper gives each point), then paints the best
// line point by point, if there is one, and posts the response.
// rst_n clears control; image memories hold no reset value.
// A pending request waits while a draw or read runs or a response is not taken.
module greedy_line_art_drawer (
    input  logic        clk,
    input  logic        rst_n,
    glad_req_if.sink    req,
    glad_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import glad_pkg::*;

    logic       invert_reg;
    logic [7:0] dark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg <= 1'b0;
            dark_reg   <= 8'd50;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INVERT:   invert_reg <= cfg_wdata[0];
                CFG_DARKNESS: dark_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    glad_core u_core (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req.valid), .req_ready(req.ready), .req(req.data),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp.data),
        .invert(invert_reg), .dark(dark_reg)
    );
endmodule

// ===== rtl/glad_stepper.sv =====
// Line point generator: holds one line and produces its points one at a time,
// using a shared restoring divider for the rounded slope term. Depends on glad_pkg.
module glad_stepper (
    input  logic                clk,
    input  logic                rst_n,
    input  glad_pkg::step_ctl_t ctl,
    input  glad_pkg::coord_t    ax,
    input  glad_pkg::coord_t    ay,
    input  glad_pkg::coord_t    bx,
    input  glad_pkg::coord_t    by,
    output glad_pkg::step_sts_t sts,
    output glad_pkg::coord_t    px,
    output glad_pkg::coord_t    py,
    output logic [glad_pkg::CntW-1:0] count
);
    import glad_pkg::*;

    localparam int NumW = 16;   // |2*(t-a)*d| + |d| stays well below this
    localparam int BitCntW = $clog2(NumW + 1);

    logic          steep_reg;
    coord_t        t_reg, t_next;
    coord_t        hi_reg;
    coord_t        base_reg;     // ax or ay, the fixed origin of the minor axis
    coord_t        org_reg;      // ay or ax, origin of the major axis
    logic signed [CoordW:0] dmin_reg;   // delta along the minor axis
    logic [CoordW-1:0] amaj_reg;        // |delta| along the major axis
    logic          majneg_reg;

    logic [NumW-1:0]  quo_reg, quo_next;
    logic [NumW:0]    rem_reg, rem_next;
    logic [NumW-1:0]  num_reg, num_next;
    logic [BitCntW-1:0] bit_reg, bit_next;
    logic             neg_reg, neg_next;
    logic             busy_reg, busy_next;

    logic signed [CoordW:0] ddx, ddy;
    logic [CoordW:0]        adx, ady;
    logic signed [2*CoordW+2:0] prod;
    logic [2*CoordW+2:0]    aprod;
    logic [NumW+1:0]        trial;
    logic [CoordW:0]        den;
    coord_t                 minor;

    assign ddx = {bx[CoordW-1], bx} - {ax[CoordW-1], ax};
    assign ddy = {by[CoordW-1], by} - {ay[CoordW-1], ay};
    assign adx = ddx[CoordW] ? -ddx : ddx;
    assign ady = ddy[CoordW] ? -ddy : ddy;

    // Numerator (t - origin) * dminor, once per point.
    assign prod = ($signed({t_reg[CoordW-1], t_reg}) - $signed({org_reg[CoordW-1], org_reg}))
                  * dmin_reg;
    assign aprod = prod[2*CoordW+2] ? -prod : prod;
    assign den = {1'b0, amaj_reg};
    assign trial = {rem_reg, num_reg[NumW-1]} - (NumW+2)'({den, 1'b0});

    always_comb
    begin
        t_next   = t_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        num_next = num_reg;
        bit_next = bit_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        if (ctl.start)
        begin
            t_next = (ady > adx) ? ((ay < by) ? ay : by) : ((ax < bx) ? ax : bx);
            busy_next = 1'b0;
        end
        else if (ctl.div_go)
        begin
            // Compute (2|num| + den) / (2 den): numerator held as 2|num|+den.
            num_next  = NumW'((aprod << 1) + (2*CoordW+3)'(den));
            rem_next  = '0;
            quo_next  = '0;
            bit_next  = BitCntW'(NumW);
            neg_next  = prod[2*CoordW+2] ^ majneg_reg;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[NumW+1])
            begin
                rem_next = trial[NumW:0];
                quo_next = {quo_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[NumW-1:0], num_reg[NumW-1]};
                quo_next = {quo_reg[NumW-2:0], 1'b0};
            end
            num_next = {num_reg[NumW-2:0], 1'b0};
            bit_next = bit_reg - 1'b1;
            if (bit_reg == BitCntW'(1))
                busy_next = 1'b0;
        end
        else if (ctl.advance)
        begin
            t_next = t_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        neg_reg <= neg_next;
        if (ctl.start)
        begin
            steep_reg <= (ady > adx);
            if (ady > adx)
            begin
                hi_reg     <= (ay < by) ? by : ay;
                base_reg   <= ax;
                org_reg    <= ay;
                dmin_reg   <= ddx;
                amaj_reg   <= ady[CoordW-1:0];
                majneg_reg <= ddy[CoordW];
            end
            else
            begin
                hi_reg     <= (ax < bx) ? bx : ax;
                base_reg   <= ay;
                org_reg    <= ax;
                dmin_reg   <= ddy;
                amaj_reg   <= adx[CoordW-1:0];
                majneg_reg <= ddx[CoordW];
            end
        end
    end

    // With a zero delta both endpoints coincide and the line is empty.
    assign minor = base_reg + (neg_reg ? -coord_t'(quo_reg) : coord_t'(quo_reg));
    assign px = steep_reg ? minor : t_reg;
    assign py = steep_reg ? t_reg : minor;
    assign count = CntW'(hi_reg - t_reg);
    assign sts.div_busy = busy_reg;
    assign sts.last     = (t_reg + 1'b1 == hi_reg);
    assign sts.empty    = (t_reg >= hi_reg);
endmodule

// ===== rtl/glad_core.sv =====
// Sequencer with the source and canvas memories: grid scan, candidate scoring,
// painting, loads and reads. Depends on glad_pkg and glad_stepper.
module glad_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  glad_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output glad_pkg::rsp_t    rsp,
    input  logic              invert,
    input  logic [7:0]        dark
);
    import glad_pkg::*;

    localparam int Pix = ImgWidth * ImgHeight;
    localparam int MemAW = $clog2(Pix);
    localparam int NumGx = (ImgWidth - Grid - 1) / Grid;   // grid columns
    localparam int NumGy = (ImgHeight - Grid - 1) / Grid;
    localparam int CandW = $clog2(NumCand);

    logic [7:0] src_mem [Pix];
    logic [7:0] cnv_mem [Pix];

    state_t state_reg, state_next;
    req_t   req_reg;
    rsp_t   rsp_reg, rsp_next;
    logic   rsp_valid_reg, rsp_valid_next;

    coord_t gi_reg, gi_next, gj_reg, gj_next;   // grid scan position
    coord_t gx_reg, gx_next, gy_reg, gy_next;
    logic [7:0] bval_reg, bval_next;
    logic   have_pix_reg, have_pix_next;

    logic [CandW-1:0] n_reg, n_next;
    logic [CandW-1:0] nq_reg, nq_next;   // offset counters
    coord_t ox_reg, ox_next, oy_reg, oy_next;
    coord_t cx, cy;
    coord_t bx_reg, bx_next, by_reg, by_next;
    logic [SumW-1:0] sum_reg, sum_next, bsum_reg, bsum_next;
    logic [CntW-1:0] len_reg, len_next, blen_reg, blen_next;
    logic   have_best_reg, have_best_next;
    logic   painting;

    step_ctl_t ctl;
    step_sts_t sts;
    coord_t px, py;
    logic [CntW-1:0] cnt;

    logic [MemAW-1:0] rd_addr, wr_addr;
    logic             src_we, cnv_we;
    logic [7:0]       src_wd, cnv_wd, src_q, cnv_q;
    logic             in_img;
    logic [SumW+CntW-1:0] lhs, rhs;

    // Raster address of an in-image point; the row term is a constant shift.
    function automatic logic [MemAW-1:0] pix_addr(input coord_t y, input coord_t x);
        return MemAW'(int'(y) * ImgWidth + int'(x));
    endfunction

    assign cx = gx_reg + ox_reg - coord_t'(CandOff);
    assign cy = gy_reg + oy_reg - coord_t'(CandOff);
    assign painting = (state_reg == ST_PAINT_INIT) || (state_reg == ST_PAINT_DIV)
                   || (state_reg == ST_PAINT_RD) || (state_reg == ST_PAINT_WR);

    glad_stepper u_step (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .ax(painting ? bx_reg : cx), .ay(painting ? by_reg : cy),
        .bx(gx_reg), .by(gy_reg),
        .sts(sts), .px(px), .py(py), .count(cnt)
    );

    assign in_img = (px >= 0) && (px < coord_t'(ImgWidth))
                 && (py >= 0) && (py < coord_t'(ImgHeight));

    always_ff @(posedge clk)
    begin
        src_q <= src_mem[rd_addr];
        cnv_q <= cnv_mem[rd_addr];
        if (src_we)
            src_mem[wr_addr] <= src_wd;
        if (cnv_we)
            cnv_mem[wr_addr] <= cnv_wd;
    end

    assign lhs = sum_reg * blen_reg;
    assign rhs = bsum_reg * len_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (req_valid && !rsp_valid_reg)
                begin
                    case (req.func)
                        FUNC_DRAW: state_next = ST_GRID_RD;
                        FUNC_READ: state_next = ST_READ;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            ST_GRID_RD:  state_next = ST_GRID_CMP;
            ST_GRID_CMP:
                if (gi_reg == coord_t'(Grid * NumGy) && gj_reg == coord_t'(Grid * NumGx))
                    state_next = ST_CAND_INIT;
                else
                    state_next = ST_GRID_RD;
            ST_CAND_INIT: state_next = ST_DIV;
            ST_DIV:       state_next = sts.empty ? ST_CAND_END : ST_PT_RD;
            ST_PT_RD:     state_next = sts.div_busy ? ST_PT_RD : ST_PT_ACC;
            ST_PT_ACC:    state_next = sts.last ? ST_CAND_END : ST_DIV;
            ST_CAND_END:
                if (n_reg == CandW'(NumCand - 1))
                    state_next = (have_best_next) ? ST_PAINT_INIT : ST_DONE;
                else
                    state_next = ST_CAND_INIT;
            ST_PAINT_INIT: state_next = ST_PAINT_DIV;
            ST_PAINT_DIV:  state_next = sts.empty ? ST_DONE : ST_PAINT_RD;
            ST_PAINT_RD:   state_next = sts.div_busy ? ST_PAINT_RD : ST_PAINT_WR;
            ST_PAINT_WR:   state_next = sts.last ? ST_DONE : ST_PAINT_DIV;
            ST_READ:      state_next = ST_DONE;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        rd_addr = '0;
        wr_addr = MemAW'(req.pixel_addr);
        src_we = 1'b0; cnv_we = 1'b0;
        src_wd = req.in_pixel;
        cnv_wd = invert ? 8'h00 : 8'hFF;
        gi_next = gi_reg; gj_next = gj_reg; gx_next = gx_reg; gy_next = gy_reg;
        bval_next = bval_reg; have_pix_next = have_pix_reg;
        n_next = n_reg; nq_next = nq_reg; ox_next = ox_reg; oy_next = oy_reg;
        bx_next = bx_reg; by_next = by_reg;
        sum_next = sum_reg; bsum_next = bsum_reg; len_next = len_reg; blen_next = blen_reg;
        have_best_next = have_best_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            ST_IDLE:
            begin
                gi_next = coord_t'(Grid); gj_next = coord_t'(Grid);
                gx_next = coord_t'(Grid); gy_next = coord_t'(Grid);
                have_pix_next = 1'b0; have_best_next = 1'b0;
                bx_next = '0; by_next = '0; bsum_next = '0; blen_next = CntW'(1);
                n_next = '0; nq_next = '0; ox_next = '0; oy_next = '0;
                len_next = '0;
                if (req_valid && !rsp_valid_reg && req.func == FUNC_LOAD
                    && 32'(req.pixel_addr) < 32'(Pix))
                begin
                    src_we = 1'b1;
                    cnv_we = 1'b1;
                end
                rd_addr = MemAW'(req.pixel_addr);
            end
            ST_GRID_RD:
                rd_addr = pix_addr(gi_reg, gj_reg);
            ST_GRID_CMP:
            begin
                if (!have_pix_reg || (invert ? src_q > bval_reg : src_q < bval_reg))
                begin
                    have_pix_next = 1'b1;
                    bval_next = src_q;
                    gx_next = gj_reg; gy_next = gi_reg;
                end
                if (gj_reg == coord_t'(Grid * NumGx))
                begin
                    gj_next = coord_t'(Grid);
                    gi_next = gi_reg + coord_t'(Grid);
                end
                else
                    gj_next = gj_reg + coord_t'(Grid);
            end
            ST_CAND_INIT:
            begin
                ctl.start = 1'b1;
                sum_next = '0;
            end
            ST_DIV:
                if (!sts.empty)
                    ctl.div_go = 1'b1;
            ST_PT_RD:
                rd_addr = pix_addr(py, px);
            ST_PT_ACC:
            begin
                if (in_img)
                    sum_next = sum_reg + SumW'(src_q);
                ctl.advance = 1'b1;
                len_next = cnt;
            end
            ST_CAND_END:
            begin
                // len_reg holds the point count captured at the first point.
                if (len_reg != '0 && (!have_best_reg ||
                    (invert ? lhs > rhs : lhs < rhs)))
                begin
                    have_best_next = 1'b1;
                    bsum_next = sum_reg; blen_next = len_reg;
                    bx_next = cx; by_next = cy;
                end
                len_next = '0;
                n_next = n_reg + 1'b1;
                // Walk the offset table: two rows of 29, then columns of 27.
                if (n_reg < CandW'(Split))
                begin
                    if (n_reg == CandW'(Split - 1))
                    begin
                        ox_next = '0; oy_next = '0; nq_next = '0;
                    end
                    else if (ox_reg == coord_t'(Grid - 1))
                    begin
                        ox_next = '0; oy_next = oy_reg + coord_t'(Grid);
                    end
                    else
                        ox_next = ox_reg + 1'b1;
                end
                else if (nq_reg == CandW'(SideRows - 1))
                begin
                    nq_next = '0; oy_next = '0; ox_next = ox_reg + coord_t'(Grid);
                end
                else
                begin
                    nq_next = nq_reg + 1'b1; oy_next = oy_reg + 1'b1;
                end
            end
            ST_PAINT_INIT:
                ctl.start = 1'b1;   // line from the best candidate end
            ST_PAINT_DIV:
                if (!sts.empty)
                    ctl.div_go = 1'b1;
            ST_PAINT_RD:
                rd_addr = pix_addr(py, px);
            ST_PAINT_WR:
            begin
                wr_addr = pix_addr(py, px);
                src_we = in_img; cnv_we = in_img;
                src_wd = invert ? sat_sub(src_q, dark) : sat_add(src_q, dark);
                cnv_wd = invert ? sat_add(cnv_q, dark) : sat_sub(cnv_q, dark);
                ctl.advance = 1'b1;
            end
            ST_READ:
                rd_addr = MemAW'(req_reg.pixel_addr);
            ST_DONE:
            begin
                rsp_valid_next = 1'b1;
                if (req_reg.func == FUNC_READ)
                begin
                    rsp_next = '0;
                    rsp_next.reply_kind = 1'b1;
                    rsp_next.out_pixel = (32'(req_reg.pixel_addr) < 32'(Pix)) ? cnv_q : 8'h00;
                end
                else
                begin
                    rsp_next.reply_kind = 1'b0;
                    rsp_next.from_x = bx_reg[7:0];
                    rsp_next.from_y = by_reg[7:0];
                    rsp_next.to_x = gx_reg[7:0];
                    rsp_next.to_y = gy_reg[7:0];
                    rsp_next.out_pixel = 8'h00;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid && !rsp_valid_reg)
            req_reg <= req;
        rsp_reg <= rsp_next;
        gi_reg <= gi_next; gj_reg <= gj_next; gx_reg <= gx_next; gy_reg <= gy_next;
        bval_reg <= bval_next; have_pix_reg <= have_pix_next;
        n_reg <= n_next; nq_reg <= nq_next; ox_reg <= ox_next; oy_reg <= oy_next;
        bx_reg <= bx_next; by_reg <= by_next;
        sum_reg <= sum_next; bsum_reg <= bsum_next;
        len_reg <= (state_reg == ST_PT_ACC && len_reg != '0) ? len_reg : len_next;
        blen_reg <= blen_next;
        have_best_reg <= have_best_next;
    end

    assign req_ready = (state_reg == ST_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;
endmodule
